### sv/scaled_glyph_row_expander_macros.svh
// assertion macros shared by the glyph row expander rtl
`ifndef SCALED_GLYPH_ROW_EXPANDER_MACROS_SVH
`define SCALED_GLYPH_ROW_EXPANDER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SGRE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold
`define SGRE_ASSERT_NEVER(name, cond, msg) \
  `SGRE_ASSERT(name, !(cond), msg)

`endif

### sv/sgre_pkg.sv
// shared types, constants and helper functions of the glyph row expander
`timescale 1ns / 1ps
`default_nettype none

package sgre_pkg;

  localparam int unsigned GLYPH_WIDTH  = 8;
  localparam int unsigned GLYPH_HEIGHT = 16;
  localparam int unsigned CHAR_COUNT   = 128;
  localparam int unsigned FONT_AW      = $clog2(CHAR_COUNT * GLYPH_HEIGHT);

  localparam logic [11:0] CUR_MAX = 12'hFFF;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PW    = $clog2(CMD_DEPTH);
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PW    = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    KIND_DRAW       = 2'd0,
    KIND_SET_CURSOR = 2'd1,
    KIND_LINE_FEED  = 2'd2,
    KIND_FONT_WRITE = 2'd3
  } kind_e;

  localparam logic [2:0] CFG_SCALE_X     = 3'd0;
  localparam logic [2:0] CFG_SCALE_Y     = 3'd1;
  localparam logic [2:0] CFG_LINE_PITCH  = 3'd2;
  localparam logic [2:0] CFG_FRAME_BASE  = 3'd3;
  localparam logic [2:0] CFG_INK_COLOR   = 3'd4;
  localparam logic [2:0] CFG_PAPER_COLOR = 3'd5;

  // scales are held already clamped to their working range
  typedef struct packed {
    logic [3:0]  sx;
    logic [2:0]  sy;
    logic [15:0] pitch;
    logic [31:0] base;
    logic [23:0] ink;
    logic [23:0] paper;
  } cfg_t;

  typedef struct packed {
    logic        is_font;
    logic [6:0]  char_code;
    logic [3:0]  glyph_row;
    logic [7:0]  pattern;
    logic [11:0] cx;
    logic [11:0] cy;
  } cmd_t;

  typedef struct packed {
    logic [31:0] row_address;
    logic [11:0] pixel_line;
    logic [63:0] row_bits;
    logic [6:0]  row_width;
    logic [23:0] ink_out;
    logic [23:0] paper_out;
    logic        last;
  } row_t;

  function automatic logic [3:0] eff_scale_x(input logic [3:0] s);
    logic [3:0] r;
    if (s == 4'd0) r = 4'd1;
    else if (s > 4'd8) r = 4'd8;
    else r = s;
    return r;
  endfunction

  function automatic logic [2:0] eff_scale_y(input logic [2:0] s);
    logic [2:0] r;
    if (s == 3'd0) r = 3'd1;
    else if (s > 3'd4) r = 3'd4;
    else r = s;
    return r;
  endfunction

  function automatic logic [11:0] sat_cursor(input logic [12:0] v);
    logic [11:0] r;
    if (v[12]) r = CUR_MAX;
    else r = v[11:0];
    return r;
  endfunction

  // pixel i takes glyph column i/sx, leftmost pixel from the msb
  function automatic logic [63:0] expand_row(input logic [7:0] pat, input logic [3:0] sx);
    logic [63:0] bits;
    logic [5:0]  col;
    logic [2:0]  bidx;
    bits = '0;
    for (int i = 0; i < 64; i++) begin
      case (sx)
        4'd2:    col = 6'(i / 2);
        4'd3:    col = 6'(i / 3);
        4'd4:    col = 6'(i / 4);
        4'd5:    col = 6'(i / 5);
        4'd6:    col = 6'(i / 6);
        4'd7:    col = 6'(i / 7);
        4'd8:    col = 6'(i / 8);
        default: col = 6'(i);
      endcase
      bidx = 3'(GLYPH_WIDTH - 1) - col[2:0];
      if (col < 6'(GLYPH_WIDTH)) bits[i] = pat[bidx];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

### sv/sgre_front.sv
// front end: accepts items, keeps the cursor and queues draw and font work
`timescale 1ns / 1ps
`default_nettype none

module sgre_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         kind_i,
  input  logic [6:0]         char_code_i,
  input  logic [3:0]         glyph_row_i,
  input  logic [7:0]         row_pattern_i,
  input  logic [11:0]        pos_x_i,
  input  logic [11:0]        pos_y_i,
  input  sgre_pkg::cfg_t     cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sgre_pkg::cmd_t     q_cmd_o
);
  import sgre_pkg::*;

  kind_e       kind;
  logic        accept;
  logic [11:0] cx_q, cx_d, cy_q, cy_d;
  logic [6:0]  w, adv_x, h, adv_y;

  assign kind   = kind_e'(kind_i);
  assign accept = push_i && !q_full_i;
  assign full_o = q_full_i;

  // glyph advance is width plus a quarter width gap, same for line height
  assign w     = {cfg_i.sx, 3'b000};
  assign adv_x = w + (w >> 2);
  assign h     = {cfg_i.sy, 4'b0000};
  assign adv_y = h + (h >> 2);

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    q_push_o = 1'b0;
    unique case (kind)
      KIND_DRAW: begin
        q_push_o = accept;
        if (accept) cx_d = sat_cursor(13'(cx_q) + 13'(adv_x));
      end
      KIND_SET_CURSOR: begin
        if (accept) begin
          cx_d = pos_x_i;
          cy_d = pos_y_i;
        end
      end
      KIND_LINE_FEED: begin
        if (accept) cy_d = sat_cursor(13'(cy_q) + 13'(adv_y));
      end
      KIND_FONT_WRITE: begin
        q_push_o = accept && ({1'b0, glyph_row_i} < 5'(GLYPH_HEIGHT));
      end
    endcase
  end

  always_comb begin
    q_cmd_o.is_font   = (kind == KIND_FONT_WRITE);
    q_cmd_o.char_code = char_code_i;
    q_cmd_o.glyph_row = glyph_row_i;
    q_cmd_o.pattern   = row_pattern_i;
    q_cmd_o.cx        = cx_q;
    q_cmd_o.cy        = cy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

endmodule

`default_nettype wire

### sv/sgre_cmd_fifo.sv
// short command queue between the front end and the row engine
`timescale 1ns / 1ps
`default_nettype none

module sgre_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  sgre_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output sgre_pkg::cmd_t rdata_o,
  output logic           empty_o
);
  import sgre_pkg::*;

  cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_PW-1:0] wp_q, rp_q;
  logic [CMD_PW:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == (CMD_PW+1)'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (CMD_PW+1)'(do_wr) - (CMD_PW+1)'(do_rd);
    end
  end

endmodule

`default_nettype wire

### sv/sgre_back.sv
// row engine: font store, row sequencer, address pipeline and result queue
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_glyph_row_expander_macros.svh"

module sgre_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sgre_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  sgre_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sgre_pkg::row_t row_o
);
  import sgre_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic   load_cmd, font_we, issue, last_row;

  logic [5:0] l_q, l_d;
  logic [1:0] sub_q, sub_d;
  logic [3:0] grow_q, grow_d;

  logic [7:0] font_mem [CHAR_COUNT*GLYPH_HEIGHT];
  logic [7:0] font_rd_q;

  logic        s1_v_q, s1_last_q;
  logic [11:0] s1_line_q;
  logic [13:0] s1_xoff_q;
  logic        s2_v_q, s2_last_q;
  logic [11:0] s2_line_q;
  logic [13:0] s2_xoff_q;
  logic [27:0] s2_prod_q;
  logic [7:0]  s2_pat_q;

  row_t              oq_q [OUT_DEPTH];
  logic [OUT_PW-1:0] oq_wp_q, oq_rp_q;
  logic [OUT_PW:0]   oq_cnt_q;
  logic              oq_rd;
  logic [OUT_PW+1:0] credit_sum;
  row_t              row_new;

  // rows in the pipeline are counted against free result slots
  assign credit_sum = (OUT_PW+2)'(oq_cnt_q) + (OUT_PW+2)'(s1_v_q) + (OUT_PW+2)'(s2_v_q);
  assign issue      = (state_q == ST_DRAW) && (credit_sum < (OUT_PW+2)'(OUT_DEPTH));
  assign last_row   = (grow_q == 4'(GLYPH_HEIGHT - 1)) && ({1'b0, sub_q} == cfg_i.sy - 3'd1);

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_cmd = 1'b0;
    font_we  = 1'b0;
    l_d      = l_q;
    sub_d    = sub_q;
    grow_d   = grow_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_font) begin
            font_we = 1'b1;
          end else begin
            load_cmd = 1'b1;
            state_d  = ST_DRAW;
            l_d      = '0;
            sub_d    = '0;
            grow_d   = '0;
          end
        end
      end
      ST_DRAW: begin
        if (issue) begin
          l_d = l_q + 6'd1;
          if (last_row) begin
            state_d = ST_IDLE;
          end else if ({1'b0, sub_q} == cfg_i.sy - 3'd1) begin
            sub_d  = '0;
            grow_d = grow_q + 4'd1;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      l_q     <= '0;
      sub_q   <= '0;
      grow_q  <= '0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      sub_q   <= sub_d;
      grow_q  <= grow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) cmd_q <= q_cmd_i;
  end

  always_ff @(posedge clk_i) begin
    if (font_we) font_mem[{q_cmd_i.char_code, q_cmd_i.glyph_row}] <= q_cmd_i.pattern;
    if (issue) font_rd_q <= font_mem[{cmd_q.char_code, grow_q}];
  end

  // stage 1: screen line, stage 2: line times pitch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_line_q <= sat_cursor(13'(cmd_q.cy) + 13'(l_q));
      s1_last_q <= last_row;
      s1_xoff_q <= {cmd_q.cx, 2'b00};
    end
    if (s1_v_q) begin
      s2_prod_q <= cfg_i.pitch * s1_line_q;
      s2_pat_q  <= font_rd_q;
      s2_line_q <= s1_line_q;
      s2_last_q <= s1_last_q;
      s2_xoff_q <= s1_xoff_q;
    end
  end

  always_comb begin
    row_new.row_address = cfg_i.base + 32'(s2_prod_q) + 32'(s2_xoff_q);
    row_new.pixel_line  = s2_line_q;
    row_new.row_bits    = expand_row(s2_pat_q, cfg_i.sx);
    row_new.row_width   = {cfg_i.sx, 3'b000};
    row_new.ink_out     = cfg_i.ink;
    row_new.paper_out   = cfg_i.paper;
    row_new.last        = s2_last_q;
  end

  assign empty_o = (oq_cnt_q == '0);
  assign oq_rd   = pop_i && !empty_o;
  assign row_o   = oq_q[oq_rp_q];

  always_ff @(posedge clk_i) begin
    if (s2_v_q) oq_q[oq_wp_q] <= row_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_v_q) oq_wp_q <= oq_wp_q + 1'b1;
      if (oq_rd) oq_rp_q <= oq_rp_q + 1'b1;
      oq_cnt_q <= oq_cnt_q + (OUT_PW+1)'(s2_v_q) - (OUT_PW+1)'(oq_rd);
    end
  end

  `SGRE_ASSERT(a_oq_room, s2_v_q |-> (oq_cnt_q < (OUT_PW+1)'(OUT_DEPTH)), "result queue overrun")
  `SGRE_ASSERT_NEVER(a_credit, credit_sum > (OUT_PW+2)'(OUT_DEPTH), "row credit exceeded")
  `SGRE_ASSERT(a_s1_src, s1_v_q |-> $past(state_q == ST_DRAW), "row issued outside draw")

endmodule

`default_nettype wire

### sv/scaled_glyph_row_expander.sv
// Text engine for a 32-bit framebuffer: a front end takes items from the push/full
// queue port, updates the pixel cursor for draws, set cursor and line feed, and
// queues draws and font row writes to a row engine, which pops each queued command
// while idle; a font row write completes as it is popped, a draw then issues one
// pixel row per cycle, 16*scale_y rows, paced by the single read port of the
// 2048 x 8 font store and by free slots in the four-entry result queue. An issued
// row passes registers s1 and s2 into the result queue and on to the empty/pop port.
// The font store has no reset; draw only characters whose rows were loaded.
`timescale 1ns / 1ps
`default_nettype none

module scaled_glyph_row_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  char_code_i,
  input  logic [3:0]  glyph_row_i,
  input  logic [7:0]  row_pattern_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] row_address_o,
  output logic [11:0] pixel_line_o,
  output logic [63:0] row_bits_o,
  output logic [6:0]  row_width_o,
  output logic [23:0] ink_out_o,
  output logic [23:0] paper_out_o,
  output logic        last_o
);
  import sgre_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, pop_cmd;
  row_t row;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sx    <= 4'd1;
      cfg_q.sy    <= 3'd1;
      cfg_q.pitch <= 16'd4096;
      cfg_q.base  <= '0;
      cfg_q.ink   <= 24'hFFFFFF;
      cfg_q.paper <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_X:     cfg_q.sx    <= eff_scale_x(cfg_data_i[3:0]);
        CFG_SCALE_Y:     cfg_q.sy    <= eff_scale_y(cfg_data_i[2:0]);
        CFG_LINE_PITCH:  cfg_q.pitch <= cfg_data_i[15:0];
        CFG_FRAME_BASE:  cfg_q.base  <= cfg_data_i;
        CFG_INK_COLOR:   cfg_q.ink   <= cfg_data_i[23:0];
        CFG_PAPER_COLOR: cfg_q.paper <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  sgre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .glyph_row_i   (glyph_row_i),
    .row_pattern_i (row_pattern_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  sgre_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (pop_cmd),
    .empty_o (q_empty)
  );

  sgre_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .row_o     (row)
  );

  assign row_address_o = row.row_address;
  assign pixel_line_o  = row.pixel_line;
  assign row_bits_o    = row.row_bits;
  assign row_width_o   = row.row_width;
  assign ink_out_o     = row.ink_out;
  assign paper_out_o   = row.paper_out;
  assign last_o        = row.last;

endmodule

`default_nettype wire

### tb/sv/scaled_glyph_row_expander_test.sv
// self-checking testbench for the scaled glyph row expander
`timescale 1ns / 1ps

module scaled_glyph_row_expander_test;
  import sgre_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam int SCRIPT_LEN = 25;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 25;
  localparam int HOLD_AT_ROW = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  ch;
    logic [3:0]  grow;
    logic [7:0]  pat;
    logic [11:0] px;
    logic [11:0] py;
    logic        typed;
    row_t        first_row;
  } glyph_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind_i = '0;
  logic [6:0]  char_code_i = '0;
  logic [3:0]  glyph_row_i = '0;
  logic [7:0]  row_pattern_i = '0;
  logic [11:0] pos_x_i = '0;
  logic [11:0] pos_y_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] row_address_o;
  logic [11:0] pixel_line_o;
  logic [63:0] row_bits_o;
  logic [6:0]  row_width_o;
  logic [23:0] ink_out_o;
  logic [23:0] paper_out_o;
  logic        last_o;

  scaled_glyph_row_expander dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .kind_i, .char_code_i, .glyph_row_i, .row_pattern_i,
    .pos_x_i, .pos_y_i, .empty, .pop,
    .row_address_o, .pixel_line_o, .row_bits_o, .row_width_o,
    .ink_out_o, .paper_out_o, .last_o
  );

  // shadow of the block: registers, cursor and font
  logic [3:0]  reg_scale_x = 4'd1;
  logic [2:0]  reg_scale_y = 3'd1;
  logic [15:0] reg_pitch = 16'd4096;
  logic [31:0] reg_base = '0;
  logic [23:0] reg_ink = 24'hFFFFFF;
  logic [23:0] reg_paper = '0;
  logic [11:0] cur_x = '0;
  logic [11:0] cur_y = '0;
  logic [7:0]  glyph_rows [0:CHAR_COUNT*GLYPH_HEIGHT-1];
  bit          row_loaded [0:CHAR_COUNT*GLYPH_HEIGHT-1];
  bit          char_ready [0:CHAR_COUNT-1];
  logic [6:0]  ready_chars [$];

  row_t        pending_rows [$];
  glyph_cmd_t  script [0:SCRIPT_LEN-1];
  int          mismatches = 0;
  int          rows_seen = 0;
  bit          calm = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [11:0] clip_cursor(input int unsigned v);
    return (v > 4095) ? CUR_MAX : 12'(v);
  endfunction

  task automatic predict_item(input glyph_cmd_t c);
    int unsigned sx, sy, rows, w, line, col, idx;
    logic [7:0] pat;
    bit complete;
    row_t r;
    sx = (reg_scale_x == 0) ? 1 : ((reg_scale_x > 8) ? 8 : reg_scale_x);
    sy = (reg_scale_y == 0) ? 1 : ((reg_scale_y > 4) ? 4 : reg_scale_y);
    case (c.kind)
      KIND_SET_CURSOR: begin
        cur_x = c.px;
        cur_y = c.py;
      end
      KIND_LINE_FEED: begin
        rows = GLYPH_HEIGHT * sy;
        cur_y = clip_cursor(cur_y + rows + rows / 4);
      end
      KIND_FONT_WRITE: begin
        idx = c.ch * GLYPH_HEIGHT + c.grow;
        glyph_rows[idx] = c.pat;
        row_loaded[idx] = 1'b1;
        complete = 1'b1;
        for (int g = 0; g < GLYPH_HEIGHT; g++)
          if (!row_loaded[c.ch * GLYPH_HEIGHT + g]) complete = 1'b0;
        if (complete && !char_ready[c.ch]) begin
          char_ready[c.ch] = 1'b1;
          ready_chars.push_back(c.ch);
        end
      end
      default: begin
        rows = GLYPH_HEIGHT * sy;
        w = GLYPH_WIDTH * sx;
        for (int l = 0; l < rows; l++) begin
          line = clip_cursor(cur_y + l);
          pat = glyph_rows[c.ch * GLYPH_HEIGHT + l / sy];
          r.row_address = reg_base + 32'(reg_pitch) * 32'(line) + 32'(cur_x) * 32'd4;
          r.pixel_line = 12'(line);
          r.row_bits = '0;
          // pixel i shows glyph column i/sx, leftmost pixel from the msb
          for (int i = 0; i < w; i++) begin
            col = i / sx;
            r.row_bits[i] = pat[GLYPH_WIDTH - 1 - col];
          end
          r.row_width = 7'(w);
          r.ink_out = reg_ink;
          r.paper_out = reg_paper;
          r.last = (l == rows - 1);
          pending_rows.push_back(r);
        end
        cur_x = clip_cursor(cur_x + w + w / 4);
      end
    endcase
  endtask

  task automatic send_item(input glyph_cmd_t c);
    int base;
    while (!calm && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= c.kind;
    char_code_i <= c.ch;
    glyph_row_i <= c.grow;
    row_pattern_i <= c.pat;
    pos_x_i <= c.px;
    pos_y_i <= c.py;
    do @(posedge clk_i); while (full);
    base = pending_rows.size();
    predict_item(c);
    if (c.typed) pending_rows[base] = c.first_row;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SCALE_X:     reg_scale_x = data[3:0];
      CFG_SCALE_Y:     reg_scale_y = data[2:0];
      CFG_LINE_PITCH:  reg_pitch = data[15:0];
      CFG_FRAME_BASE:  reg_base = data;
      CFG_INK_COLOR:   reg_ink = data[23:0];
      CFG_PAPER_COLOR: reg_paper = data[23:0];
      default: ;
    endcase
  endtask

  task automatic program_phase(input int phase);
    logic [31:0] vals [0:5];
    for (int i = 0; i < 6; i++) vals[i] = $urandom;
    case (phase)
      0: begin
        vals[CFG_SCALE_X][3:0] = 4'd8;
        vals[CFG_SCALE_Y][2:0] = 3'd4;
        vals[CFG_LINE_PITCH][15:0] = 16'hFFFF;
        vals[CFG_FRAME_BASE] = 32'hFFFFFFFF;
        vals[CFG_INK_COLOR][23:0] = 24'h000000;
        vals[CFG_PAPER_COLOR][23:0] = 24'hFFFFFF;
      end
      1: begin
        // zero scales act as one
        vals[CFG_SCALE_X][3:0] = 4'd0;
        vals[CFG_SCALE_Y][2:0] = 3'd0;
        vals[CFG_LINE_PITCH][15:0] = 16'h0000;
        vals[CFG_FRAME_BASE] = 32'h0;
        vals[CFG_INK_COLOR][23:0] = 24'hFFFFFF;
        vals[CFG_PAPER_COLOR][23:0] = 24'h000000;
      end
      2: begin
        // scales above the limit clamp
        vals[CFG_SCALE_X][3:0] = 4'd15;
        vals[CFG_SCALE_Y][2:0] = 3'd7;
      end
      3: begin
        vals[CFG_SCALE_X][3:0] = 4'd1;
        vals[CFG_SCALE_Y][2:0] = 3'd1;
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) write_reg(3'(i), vals[i]);
    if (phase == 0) write_reg(CFG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // nothing left in flight, then time for queued font writes to retire
  task automatic wait_idle();
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    $error("%s: expected %0h, got %0h", name, want, seen);
    mismatches++;
  endtask

  // result side: check each popped transaction, stall at random
  initial begin
    row_t got, want;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = '{row_address_o, pixel_line_o, row_bits_o, row_width_o,
                ink_out_o, paper_out_o, last_o};
        rows_seen++;
        if (pending_rows.size() == 0) begin
          $error("unexpected row: address %0h line %0d", got.row_address, got.pixel_line);
          mismatches++;
        end else begin
          want = pending_rows.pop_front();
          if (got.row_address !== want.row_address)
            flag_field("row_address", want.row_address, got.row_address);
          if (got.pixel_line !== want.pixel_line)
            flag_field("pixel_line", want.pixel_line, got.pixel_line);
          if (got.row_bits !== want.row_bits)
            flag_field("row_bits", want.row_bits, got.row_bits);
          if (got.row_width !== want.row_width)
            flag_field("row_width", want.row_width, got.row_width);
          if (got.ink_out !== want.ink_out)
            flag_field("ink_out", want.ink_out, got.ink_out);
          if (got.paper_out !== want.paper_out)
            flag_field("paper_out", want.paper_out, got.paper_out);
          if (got.last !== want.last)
            flag_field("last", want.last, got.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held && rows_seen >= HOLD_AT_ROW) begin
        // long back-pressure so both queues fill and full rises
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    glyph_cmd_t c;
    int sent, r, drain;
    logic [6:0] ch;
    script = '{
      '{KIND_FONT_WRITE, 7'd127, 4'd0,  8'hFF, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd1,  8'h80, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd2,  8'h01, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd3,  8'hAA, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd4,  8'h55, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd5,  8'h00, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd6,  8'h3C, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd7,  8'hC3, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd8,  8'h0F, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd9,  8'hF0, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd10, 8'h81, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd11, 8'h7E, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd12, 8'h18, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd13, 8'hE7, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd14, 8'h24, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_FONT_WRITE, 7'd127, 4'd15, 8'hDB, 12'd0, 12'd0, 1'b0, '0},
      // first draw at the reset cursor and reset registers
      '{KIND_DRAW, 7'd127, 4'd0, 8'h00, 12'd0, 12'd0, 1'b1,
        '{32'h0000_0000, 12'd0, 64'hFF, 7'd8, 24'hFFFFFF, 24'h000000, 1'b0}},
      '{KIND_SET_CURSOR, 7'd0, 4'd0, 8'h00, 12'd4095, 12'd4095, 1'b0, '0},
      // cursor at the far corner, every line saturated
      '{KIND_DRAW, 7'd127, 4'd0, 8'h00, 12'd0, 12'd0, 1'b1,
        '{32'h0100_2FFC, 12'd4095, 64'hFF, 7'd8, 24'hFFFFFF, 24'h000000, 1'b0}},
      '{KIND_LINE_FEED, 7'd0, 4'd0, 8'h00, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_SET_CURSOR, 7'd0, 4'd0, 8'h00, 12'd0, 12'd4090, 1'b0, '0},
      '{KIND_DRAW, 7'd127, 4'd0, 8'h00, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_SET_CURSOR, 7'd0, 4'd0, 8'h00, 12'd4090, 12'd100, 1'b0, '0},
      '{KIND_DRAW, 7'd127, 4'd0, 8'h00, 12'd0, 12'd0, 1'b0, '0},
      '{KIND_LINE_FEED, 7'd0, 4'd0, 8'h00, 12'd0, 12'd0, 1'b0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (script[i]) send_item(script[i]);
    push <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      program_phase(phase);
      calm = (phase == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        c.ch = 7'($urandom);
        c.grow = 4'($urandom);
        c.pat = 8'($urandom);
        c.px = 12'($urandom);
        c.py = 12'($urandom);
        c.typed = 1'b0;
        c.first_row = '0;
        r = $urandom_range(0, 99);
        if (ready_chars.size() == 0 || r < 8) begin
          // load a whole glyph so that it can be drawn
          ch = 7'($urandom);
          for (int g = 0; g < GLYPH_HEIGHT; g++) begin
            c.kind = KIND_FONT_WRITE;
            c.ch = ch;
            c.grow = 4'(g);
            c.pat = 8'($urandom);
            c.px = 12'($urandom);
            c.py = 12'($urandom);
            send_item(c);
          end
          sent += GLYPH_HEIGHT;
        end else begin
          if (r < 60) begin
            c.kind = KIND_DRAW;
            c.ch = ready_chars[$urandom_range(0, ready_chars.size() - 1)];
          end else if (r < 75) begin
            c.kind = KIND_SET_CURSOR;
            if ($urandom_range(0, 1) == 0) begin
              c.px = 12'($urandom_range(0, 600));
              c.py = 12'($urandom_range(0, 600));
            end
          end else if (r < 87) begin
            c.kind = KIND_LINE_FEED;
          end else begin
            c.kind = KIND_FONT_WRITE;
          end
          send_item(c);
          sent++;
        end
      end
      push <= 1'b0;
    end
    calm = 1'b0;

    drain = 0;
    while (pending_rows.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (32) @(posedge clk_i);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_rows.size() != 0)
        $error("%0d expected rows never arrived", pending_rows.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
